### hw/rtl/boundary_tag_next_fit_allocator_defines.svh
// ----------------------------------------------------------------------------
// Assertion macros for the boundary-tag heap manager
// Concurrent checks that can be compiled out with NO_ASSERTIONS.
// ----------------------------------------------------------------------------
`ifndef BOUNDARY_TAG_NEXT_FIT_ALLOCATOR_DEFINES_SVH
`define BOUNDARY_TAG_NEXT_FIT_ALLOCATOR_DEFINES_SVH
`ifndef NO_ASSERTIONS
`define BTNF_ASSERT_ALWAYS(lbl, clk, rst, cond) \
  lbl: assert property (@(posedge clk) disable iff (rst) (cond)) \
    else $error("heap manager check failed");
`define BTNF_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("heap manager sequence check failed");
`else
`define BTNF_ASSERT_ALWAYS(lbl, clk, rst, cond)
`define BTNF_ASSERT_NEXT(lbl, clk, rst, ante, cons)
`endif
`endif

### hw/rtl/btnf_pkg.sv
// ----------------------------------------------------------------------------
// btnf_pkg
// Shared widths, constants and helpers of the boundary-tag heap manager.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
package btnf_pkg;
  localparam int HEAP_BYTES = 65536;
  localparam int HEAP_WORDS = HEAP_BYTES / 4;
  localparam int IDX_W      = $clog2(HEAP_WORDS);
  localparam int BRK_W      = $clog2(HEAP_BYTES) + 1;
  localparam int AW         = $clog2(HEAP_BYTES) + 4;
  localparam int CHUNK_W    = 17;

  typedef logic [AW-1:0] addr_t;

  localparam addr_t TAG_BYTES  = AW'(4);
  localparam addr_t PAIR_BYTES = AW'(8);
  localparam addr_t MIN_BLOCK  = AW'(16);
  localparam addr_t HEAP_LIMIT = AW'(HEAP_BYTES);
  localparam logic [CHUNK_W-1:0] CHUNK_RESET = CHUNK_W'(4096);

  localparam logic [1:0] REQ_INIT  = 2'd0;
  localparam logic [1:0] REQ_ALLOC = 2'd1;
  localparam logic [1:0] REQ_FREE  = 2'd2;

  typedef struct packed {
    logic               we;
    logic [IDX_W-1:0]   waddr;
    addr_t              wdata;
    logic [IDX_W-1:0]   raddr;
  } mem_req_t;

  function automatic addr_t tag_size(input addr_t x);
    tag_size = {x[AW-1:3], 3'b000};
  endfunction
endpackage

### hw/rtl/btnf_store.sv
// ----------------------------------------------------------------------------
// btnf_store
// Heap word store: one write port and one registered read port.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
module btnf_store (
  input  logic              clk,
  input  btnf_pkg::mem_req_t req,
  output btnf_pkg::addr_t   rdata
);
  btnf_pkg::addr_t mem [btnf_pkg::HEAP_WORDS];

  always_ff @(posedge clk) begin
    if (req.we) begin
      mem[req.waddr] <= req.wdata;
    end
    rdata <= mem[req.raddr];
  end
endmodule

### hw/rtl/boundary_tag_next_fit_allocator.sv
// ----------------------------------------------------------------------------
// boundary_tag_next_fit_allocator
// Heap manager over a tagged word store with next-fit placement.
// ----------------------------------------------------------------------------
// Every store access passes through an access state of the sequencer (address,
// then data), and the shared store address sets the pace. Init writes the
// prologue and epilogue tags and grows the heap; free rewrites the block's tags
// and coalesces; allocate walks block headers in the next-fit search, then
// splits, grows and coalesces as needed. One request is handled at a time; a new
// request is accepted as soon as the previous result sits in the output register.
`timescale 1ns / 1ps
`include "boundary_tag_next_fit_allocator_defines.svh"
module boundary_tag_next_fit_allocator (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [1:0]  req_type,
  input  logic [15:0] alloc_size,
  input  logic [15:0] block_addr,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [15:0] result_addr,
  output logic        status,
  input  logic        cfg_wr_en,
  input  logic [16:0] cfg_wr_data
);
  typedef enum logic [5:0] {
    S_IDLE, S_RD, S_WR, S_I1, S_I2, S_I3, S_G0, S_G1, S_G2,
    S_M0, S_M1, S_M2, S_M3, S_M4, S_M5, S_M6, S_M7, S_M8, S_M9, S_MR,
    S_SL, S_SC, S_C0, S_C1, S_C2, S_C3, S_C4, S_C5, S_F1, S_F2, S_OK, S_FIN
  } state_t;

  state_t state, ret;
  btnf_pkg::addr_t p, prev, nxt, ma, md, sz, psz, prevsz, need, gbytes;
  logic pu, pass2;
  logic [1:0] op;
  logic [btnf_pkg::BRK_W-1:0] brk;
  logic [15:0] rover;
  logic [btnf_pkg::CHUNK_W-1:0] chunk;
  logic [15:0] res_q;
  logic st_q;

  btnf_pkg::mem_req_t mreq;
  btnf_pkg::addr_t rdata, rd_sz, brk_x, rov_x, gw, gsz0, gsz, need_in, chunk_x;
  logic rd_used;

  assign mreq.we    = (state == S_WR);
  assign mreq.waddr = ma[btnf_pkg::IDX_W+1:2];
  assign mreq.wdata = md;
  assign mreq.raddr = ma[btnf_pkg::IDX_W+1:2];

  btnf_store u_store (.clk(clk), .req(mreq), .rdata(rdata));

  assign rd_sz   = btnf_pkg::tag_size(rdata);
  assign rd_used = rdata[0];
  assign brk_x   = btnf_pkg::AW'(brk);
  assign rov_x   = btnf_pkg::AW'(rover);
  assign chunk_x = btnf_pkg::AW'(chunk);
  assign in_ready = (state == S_IDLE) && !rst;

  // Grow amount: whole words, rounded up to an even count, at least 16 bytes.
  assign gw   = gbytes >> 2;
  assign gsz0 = (gw + btnf_pkg::AW'(gw[0])) << 2;
  assign gsz  = (gsz0 < btnf_pkg::MIN_BLOCK) ? btnf_pkg::MIN_BLOCK : gsz0;

  assign need_in = (alloc_size <= 16'd8) ? btnf_pkg::MIN_BLOCK
                 : ((btnf_pkg::AW'(alloc_size) + btnf_pkg::AW'(15)) & ~btnf_pkg::AW'(7));

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      ret       <= S_IDLE;
      brk       <= '0;
      rover     <= '0;
      chunk     <= btnf_pkg::CHUNK_RESET;
      out_valid <= 1'b0;
    end else begin
      if (cfg_wr_en) begin
        chunk <= cfg_wr_data;
      end
      if (out_valid && out_ready && state != S_FIN) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (in_valid) begin
            op    <= req_type;
            res_q <= '0;
            st_q  <= 1'b1;
            case (req_type)
              btnf_pkg::REQ_INIT: begin
                brk    <= btnf_pkg::BRK_W'(16);
                rover  <= 16'd8;
                gbytes <= chunk_x;
                ma     <= '0;
                md     <= '0;
                ret    <= S_I1;
                state  <= S_WR;
              end
              btnf_pkg::REQ_ALLOC: begin
                if (brk != '0 && alloc_size != '0) begin
                  need  <= need_in;
                  p     <= rov_x;
                  pass2 <= 1'b0;
                  state <= S_SL;
                end else begin
                  state <= S_FIN;
                end
              end
              btnf_pkg::REQ_FREE: begin
                if (brk != '0 && block_addr[2:0] == 3'd0 && block_addr >= 16'd16) begin
                  p     <= btnf_pkg::AW'(block_addr);
                  ma    <= btnf_pkg::AW'(block_addr) - btnf_pkg::TAG_BYTES;
                  ret   <= S_F1;
                  state <= S_RD;
                end else begin
                  state <= S_FIN;
                end
              end
              default: state <= S_FIN;
            endcase
          end
        end
        S_RD: state <= ret;
        S_WR: state <= ret;
        S_I1: begin
          ma <= btnf_pkg::AW'(4);  md <= btnf_pkg::AW'(9); ret <= S_I2; state <= S_WR;
        end
        S_I2: begin
          ma <= btnf_pkg::AW'(8);  md <= btnf_pkg::AW'(9); ret <= S_I3; state <= S_WR;
        end
        S_I3: begin
          ma <= btnf_pkg::AW'(12); md <= btnf_pkg::AW'(1); ret <= S_G0; state <= S_WR;
        end
        S_G0: begin
          if (brk_x + gsz > btnf_pkg::HEAP_LIMIT) begin
            res_q <= '0;
            st_q  <= 1'b1;
            state <= S_FIN;
          end else begin
            p     <= brk_x;
            brk   <= brk + gsz[btnf_pkg::BRK_W-1:0];
            sz    <= gsz;
            ma    <= brk_x - btnf_pkg::TAG_BYTES;
            md    <= gsz;
            ret   <= S_G1;
            state <= S_WR;
          end
        end
        S_G1: begin
          ma <= p + sz - btnf_pkg::PAIR_BYTES; md <= sz; ret <= S_G2; state <= S_WR;
        end
        S_G2: begin
          // New epilogue header.
          ma <= p + sz - btnf_pkg::TAG_BYTES; md <= btnf_pkg::AW'(1);
          ret <= S_M0; state <= S_WR;
        end
        S_M0: begin
          ma <= p - btnf_pkg::PAIR_BYTES; ret <= S_M1; state <= S_RD;
        end
        S_M1: begin
          prev  <= p - rd_sz;
          ma    <= p - rd_sz - btnf_pkg::TAG_BYTES;
          ret   <= S_M2;
          state <= S_RD;
        end
        S_M2: begin
          prevsz <= rd_sz;
          ma     <= prev + rd_sz - btnf_pkg::PAIR_BYTES;
          ret    <= S_M3;
          state  <= S_RD;
        end
        S_M3: begin
          pu <= rd_used; ma <= p - btnf_pkg::TAG_BYTES; ret <= S_M4; state <= S_RD;
        end
        S_M4: begin
          psz   <= rd_sz;
          nxt   <= p + rd_sz;
          ma    <= p + rd_sz - btnf_pkg::TAG_BYTES;
          ret   <= S_M5;
          state <= S_RD;
        end
        S_M5: begin
          if (pu && rd_used) begin
            sz    <= psz;
            state <= S_MR;
          end else if (pu) begin
            sz    <= psz + rd_sz;
            ma    <= p - btnf_pkg::TAG_BYTES;
            md    <= psz + rd_sz;
            ret   <= S_M6;
            state <= S_WR;
          end else if (rd_used) begin
            sz    <= psz + prevsz;
            ma    <= p + psz - btnf_pkg::PAIR_BYTES;
            md    <= psz + prevsz;
            ret   <= S_M7;
            state <= S_WR;
          end else begin
            // Both neighbors free: fetch the footer of the next block.
            nxt   <= nxt + rd_sz - btnf_pkg::PAIR_BYTES;
            ma    <= nxt + rd_sz - btnf_pkg::PAIR_BYTES;
            ret   <= S_M8;
            state <= S_RD;
          end
        end
        S_M6: begin
          ma <= p + sz - btnf_pkg::PAIR_BYTES; md <= sz; ret <= S_MR; state <= S_WR;
        end
        S_M7: begin
          ma <= prev - btnf_pkg::TAG_BYTES; md <= sz; p <= prev; ret <= S_MR;
          state <= S_WR;
        end
        S_M8: begin
          sz    <= psz + prevsz + rd_sz;
          ma    <= prev - btnf_pkg::TAG_BYTES;
          md    <= psz + prevsz + rd_sz;
          ret   <= S_M9;
          state <= S_WR;
        end
        S_M9: begin
          ma <= nxt; md <= sz; p <= prev; ret <= S_MR; state <= S_WR;
        end
        S_MR: begin
          // The rover follows a block that the merge swallowed.
          if (p - btnf_pkg::TAG_BYTES < rov_x &&
              p + btnf_pkg::tag_size(sz) - btnf_pkg::PAIR_BYTES > rov_x) begin
            rover <= p[15:0];
          end
          state <= (op == btnf_pkg::REQ_ALLOC) ? S_C0 : S_OK;
        end
        S_SL: begin
          if (p < brk_x && (!pass2 || p < rov_x)) begin
            ma    <= p - btnf_pkg::TAG_BYTES;
            ret   <= S_SC;
            state <= S_RD;
          end else if (!pass2) begin
            pass2 <= 1'b1;
            p     <= btnf_pkg::PAIR_BYTES;
          end else begin
            gbytes <= (need > chunk_x) ? need : chunk_x;
            state  <= S_G0;
          end
        end
        S_SC: begin
          if (rd_sz == '0) begin
            if (!pass2) begin
              pass2 <= 1'b1;
              p     <= btnf_pkg::PAIR_BYTES;
              state <= S_SL;
            end else begin
              gbytes <= (need > chunk_x) ? need : chunk_x;
              state  <= S_G0;
            end
          end else if (!rd_used && rd_sz >= need) begin
            rover <= p[15:0];
            state <= S_C0;
          end else begin
            p     <= p + rd_sz;
            state <= S_SL;
          end
        end
        S_C0: begin
          ma <= p - btnf_pkg::TAG_BYTES; ret <= S_C1; state <= S_RD;
        end
        S_C1: begin
          psz <= rd_sz;
          ma  <= p - btnf_pkg::TAG_BYTES;
          if (rd_sz - need >= btnf_pkg::MIN_BLOCK) begin
            md  <= need | btnf_pkg::AW'(1);
            ret <= S_C2;
          end else begin
            md  <= rd_sz | btnf_pkg::AW'(1);
            ret <= S_C5;
          end
          state <= S_WR;
        end
        S_C2: begin
          ma <= p + need - btnf_pkg::PAIR_BYTES; md <= need | btnf_pkg::AW'(1);
          ret <= S_C3; state <= S_WR;
        end
        S_C3: begin
          ma <= p + need - btnf_pkg::TAG_BYTES; md <= psz - need;
          ret <= S_C4; state <= S_WR;
        end
        S_C4: begin
          ma <= p + psz - btnf_pkg::PAIR_BYTES; md <= psz - need;
          ret <= S_OK; state <= S_WR;
        end
        S_C5: begin
          ma <= p + psz - btnf_pkg::PAIR_BYTES; md <= psz | btnf_pkg::AW'(1);
          ret <= S_OK; state <= S_WR;
        end
        S_F1: begin
          if (rd_used && rd_sz >= btnf_pkg::MIN_BLOCK && p + rd_sz <= brk_x) begin
            sz    <= rd_sz;
            ma    <= p - btnf_pkg::TAG_BYTES;
            md    <= rd_sz;
            ret   <= S_F2;
            state <= S_WR;
          end else begin
            state <= S_FIN;
          end
        end
        S_F2: begin
          ma <= p + sz - btnf_pkg::PAIR_BYTES; md <= sz; ret <= S_M0; state <= S_WR;
        end
        S_OK: begin
          res_q <= (op == btnf_pkg::REQ_ALLOC) ? p[15:0] : 16'd0;
          st_q  <= 1'b0;
          state <= S_FIN;
        end
        S_FIN: begin
          if (!out_valid || out_ready) begin
            out_valid   <= 1'b1;
            result_addr <= res_q;
            status      <= st_q;
            state       <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  `BTNF_ASSERT_ALWAYS(a_brk_bound, clk, rst, brk <= btnf_pkg::BRK_W'(btnf_pkg::HEAP_BYTES) && brk[2:0] == 3'd0)
  `BTNF_ASSERT_ALWAYS(a_rover_align, clk, rst, rover[2:0] == 3'd0)
  `BTNF_ASSERT_NEXT(a_busy_after_transfer, clk, rst, in_valid && in_ready, !in_ready)
endmodule
